/* design/esa_pkg.sv */
package esa_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHANGE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_SCALE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_START = 2'd3;

  localparam logic [14:0] MAX_CHANGE_RST  = 15'd32767;
  localparam logic [16:0] MODULUS_RST     = 17'd65536;
  localparam logic [7:0]  ACCEL_SCALE_RST = 8'd8;
  localparam logic [15:0] DECAY_START_RST = 16'd10;

  localparam logic [15:0] ACCEL_MAX = 16'd32767;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_APPLY  = 1'b1;

  // restoring divide of a 31-bit magnitude, one quotient bit per step
  localparam int unsigned DIV_STEPS = 31;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  typedef struct packed {
    logic load;
    logic calc;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage

/* design/encoder_step_accelerator_top.sv */
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: counter_sample, current_value, max_value,
//                                  min_value; tuser: op
// m_*      out  m_tvalid/m_tready  tdata: steps_now, new_value; tuser: changed
// cfg_*    in   cfg_we             cfg_index selects register, cfg_data value
//
// A sample with an acceleration bonus is registered after its request is taken, passing
// through calc, a 31-step serial divide by acceleration_scale and commit; other requests go from calc to commit.
// One request is in work at a time; the next is taken the cycle after the result is
// registered.
// A stalled result holds the output register; the following request runs up to commit.
// rst is synchronous and restores register defaults and clears the control, tracking and pending-step state.
module encoder_step_accelerator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [15:0] counter_sample, [23:16] current_value, [31:24] max_value, [39:32] min_value
  input  logic [esa_pkg::IN_DATA_W-1:0]    s_tdata,
  // [0] op
  input  logic [0:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [31:0] steps_now, [39:32] new_value
  output logic [esa_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [0] changed
  output logic [0:0]                       m_tuser,
  input  logic                             cfg_we,
  input  logic [esa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [esa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  esa_pkg::cmd_t cmd;
  esa_pkg::sts_t sts;
  logic [31:0]   steps_now;
  logic [7:0]    new_value;
  logic          changed;

  esa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  esa_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (s_tuser[0]),
    .counter_sample (s_tdata[15:0]),
    .current_value  (s_tdata[23:16]),
    .max_value      (s_tdata[31:24]),
    .min_value      (s_tdata[39:32]),
    .cmd            (cmd),
    .sts            (sts),
    .steps_now      (steps_now),
    .new_value      (new_value),
    .changed        (changed)
  );

  assign m_tdata = {new_value, steps_now};
  assign m_tuser = changed;

  a_reset_clear: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in work");

  a_changed_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[31:0] == '0)
    else $error("apply left steps pending");

  a_ready_needs_free: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped");

endmodule

/* design/esa_ctrl.sv */
module esa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  esa_pkg::sts_t sts,
  output esa_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t                         state;
  logic [esa_pkg::DIV_CNT_W-1:0] count;
  logic                          out_free;

  assign out_free     = !m_tvalid || m_tready;
  assign s_tready     = (state == S_IDLE);
  assign cmd.load     = s_tready && s_tvalid;
  assign cmd.calc     = (state == S_CALC);
  assign cmd.div_step = (state == S_DIV);
  assign cmd.commit   = (state == S_COMMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          count <= '0;
          state <= sts.need_div ? S_DIV : S_COMMIT;
        end
        S_DIV: begin
          count <= count + 1'b1;
          if (count == esa_pkg::DIV_CNT_W'(esa_pkg::DIV_STEPS - 1)) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/esa_datapath.sv */
module esa_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [esa_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [esa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              op,
  input  logic [15:0]                       counter_sample,
  input  logic [7:0]                        current_value,
  input  logic [7:0]                        max_value,
  input  logic [7:0]                        min_value,
  input  esa_pkg::cmd_t                     cmd,
  output esa_pkg::sts_t                     sts,
  output logic [31:0]                       steps_now,
  output logic [7:0]                        new_value,
  output logic                              changed
);

  logic [14:0] max_change;
  logic [16:0] counter_modulus;
  logic [7:0]  acceleration_scale;
  logic [15:0] decay_start;

  logic [15:0] last_counter;
  logic [15:0] last_delta;
  logic [15:0] accel;
  logic [15:0] decay_left;
  logic [31:0] pending_steps;

  logic        op_r;
  logic [15:0] sample_r;
  logic [7:0]  cur_r;
  logic [7:0]  maxv_r;
  logic [7:0]  minv_r;

  logic [15:0] delta_r;
  logic        neg_r;
  logic        use_bonus_r;
  logic [30:0] dq;
  logic [7:0]  rem;

  // delta and wrap correction
  logic [15:0]        diff;
  logic signed [16:0] d0;
  logic signed [16:0] mc17;
  logic signed [17:0] mod18;
  logic signed [17:0] dcor;
  logic [15:0]        dnew;
  logic               same_dir;
  logic signed [32:0] prod;
  logic signed [32:0] prod_abs;

  assign diff  = sample_r - last_counter;
  assign d0    = $signed({diff[15], diff});
  assign mc17  = $signed({2'b00, max_change});
  assign mod18 = $signed({1'b0, counter_modulus});

  always_comb begin
    if (d0 > mc17) begin
      dcor = $signed({d0[16], d0}) - mod18;
    end else if (d0 < -mc17) begin
      dcor = $signed({d0[16], d0}) + mod18;
    end else begin
      dcor = $signed({d0[16], d0});
    end
  end

  assign dnew     = dcor[15:0];
  assign same_dir = (dnew[15] == last_delta[15]);
  assign prod     = $signed({{17{dnew[15]}}, dnew}) * $signed({17'd0, accel});
  assign prod_abs = prod[32] ? -prod : prod;

  assign sts.need_div = (op_r == esa_pkg::OP_SAMPLE) && (dnew != '0) && same_dir &&
                        (accel != '0) && (acceleration_scale != '0);

  // divider step
  logic [8:0] trial;
  logic [8:0] trial_sub;
  logic       ge;

  assign trial     = {rem, dq[30]};
  assign trial_sub = trial - {1'b0, acceleration_scale};
  assign ge        = (trial >= {1'b0, acceleration_scale});

  // commit
  logic [31:0]        quo32;
  logic [31:0]        bonus;
  logic [31:0]        pend_s;
  logic signed [33:0] sum34;
  logic [7:0]         clamp;

  assign quo32  = {1'b0, dq};
  assign bonus  = use_bonus_r ? (neg_r ? -quo32 : quo32) : '0;
  assign pend_s = pending_steps + {{16{delta_r[15]}}, delta_r} + bonus;
  assign sum34  = $signed({{2{pending_steps[31]}}, pending_steps}) +
                  $signed({26'd0, cur_r});

  always_comb begin
    if ($signed({26'd0, maxv_r}) < sum34) begin
      clamp = maxv_r;
    end else if ($signed({26'd0, minv_r}) > sum34) begin
      clamp = minv_r;
    end else begin
      clamp = sum34[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_change         <= esa_pkg::MAX_CHANGE_RST;
      counter_modulus    <= esa_pkg::MODULUS_RST;
      acceleration_scale <= esa_pkg::ACCEL_SCALE_RST;
      decay_start        <= esa_pkg::DECAY_START_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        esa_pkg::REG_MAX_CHANGE:  max_change         <= cfg_data[14:0];
        esa_pkg::REG_MODULUS:     counter_modulus    <= cfg_data[16:0];
        esa_pkg::REG_ACCEL_SCALE: acceleration_scale <= cfg_data[7:0];
        esa_pkg::REG_DECAY_START: decay_start        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op;
      sample_r <= counter_sample;
      cur_r    <= current_value;
      maxv_r   <= max_value;
      minv_r   <= min_value;
    end
    if (cmd.calc) begin
      delta_r     <= dnew;
      neg_r       <= dnew[15];
      use_bonus_r <= sts.need_div;
      dq          <= prod_abs[30:0];
      rem         <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? trial_sub[7:0] : trial[7:0];
      dq  <= {dq[29:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_counter  <= '0;
      last_delta    <= '0;
      accel         <= '0;
      decay_left    <= '0;
      pending_steps <= '0;
    end else if (cmd.commit) begin
      if (op_r == esa_pkg::OP_SAMPLE) begin
        if (delta_r != '0) begin
          pending_steps <= pend_s;
          if (delta_r[15] == last_delta[15]) begin
            if (accel < esa_pkg::ACCEL_MAX) begin
              accel <= accel + 1'b1;
            end
          end else begin
            accel <= '0;
          end
        end else if (decay_left != '0) begin
          decay_left <= decay_left - 1'b1;
        end else begin
          decay_left <= decay_start;
          if (accel != '0) begin
            accel <= accel - 1'b1;
          end
        end
        last_counter <= sample_r;
        last_delta   <= delta_r;
      end else if (pending_steps != '0) begin
        pending_steps <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_r == esa_pkg::OP_SAMPLE) begin
        steps_now <= (delta_r != '0) ? pend_s : pending_steps;
        new_value <= cur_r;
        changed   <= 1'b0;
      end else if (pending_steps != '0) begin
        steps_now <= '0;
        new_value <= clamp;
        changed   <= 1'b1;
      end else begin
        steps_now <= pending_steps;
        new_value <= cur_r;
        changed   <= 1'b0;
      end
    end
  end

endmodule
